// ----- design/kdtle_pkg.sv -----
// Package for the key-driven text line editor.
// Holds default geometry, stream widths and the scan and character codes.
// No dependencies.
package kdtle_pkg;

  localparam int unsigned LinesDefault   = 100;
  localparam int unsigned ColumnsDefault = 120;

  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 40;
  localparam int unsigned CharWidth    = 7;

  localparam logic [15:0] ScanEscape   = 16'h0001;
  localparam logic [15:0] ScanF1       = 16'h000B;
  localparam logic [15:0] ScanF2       = 16'h000C;
  localparam logic [15:0] ScanF3       = 16'h000D;
  localparam logic [15:0] ScanF4       = 16'h000E;
  localparam logic [15:0] ScanF5       = 16'h000F;
  localparam logic [15:0] ScanF6       = 16'h0010;
  localparam logic [15:0] ScanF8       = 16'h0012;

  localparam logic [15:0] CharBackspace = 16'h0008;
  localparam logic [15:0] CharTab       = 16'h0009;
  localparam logic [15:0] CharLineFeed  = 16'h000A;
  localparam logic [15:0] CharReturn    = 16'h000D;
  localparam logic [15:0] CharSpace     = 16'h0020;
  localparam logic [15:0] CharDelete    = 16'h007F;

  localparam logic [1:0] ScaleMin     = 2'd1;
  localparam logic [1:0] ScaleMax     = 2'd3;
  localparam logic [3:0] ColourLast   = 4'd9;
  localparam logic [2:0] TabSpaces    = 3'd4;

endpackage

// ----- design/kdtle_store.sv -----
// Character store of the text line editor: one write port, one registered read port.
// Runs a clearing pass after reset and reports it as busy.
// Depends on kdtle_pkg.
module kdtle_store #(
  parameter int unsigned LINES   = kdtle_pkg::LinesDefault,
  parameter int unsigned COLUMNS = kdtle_pkg::ColumnsDefault
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      wr_en_i,
  input  logic [$clog2(LINES)+$clog2(COLUMNS)-1:0]  wr_addr_i,
  input  logic [kdtle_pkg::CharWidth-1:0]           wr_data_i,
  input  logic                                      rd_en_i,
  input  logic [$clog2(LINES)+$clog2(COLUMNS)-1:0]  rd_addr_i,
  output logic [kdtle_pkg::CharWidth-1:0]           rd_data_o,
  output logic                                      busy_o
);

  localparam int unsigned AW    = $clog2(LINES) + $clog2(COLUMNS);
  localparam int unsigned DEPTH = LINES * (2 ** $clog2(COLUMNS));

  logic [kdtle_pkg::CharWidth-1:0] mem [DEPTH];
  logic [kdtle_pkg::CharWidth-1:0] rd_data_q;
  logic                            clr_q, clr_d;
  logic [AW-1:0]                   clr_addr_q, clr_addr_d;
  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [kdtle_pkg::CharWidth-1:0] wdata;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_q || wr_en_i;
  assign waddr = clr_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule

// ----- design/key_driven_text_line_editor.sv -----
// Top level of the key-driven text line editor: key decode, write sequencer, result stage.
// Depends on kdtle_pkg and kdtle_store.
//
// Each transfer on the input stream is a key event (tuser 0) or a read request (tuser 1)
// and gives exactly one result transfer with the status after the step and the stored
// character at the requested position. The sequencer writes one cell at a time through the
// single store write port, then issues the store read; reads and setting keys write no cell,
// backspace and enter a terminator, a printable character itself and a terminator, tab up to
// four spaces and a terminator. The read waits while an untaken result holds the output;
// the result appears in the cycle after it. A new item is taken in the cycle its predecessor
// issues its read, while an earlier result may wait. After reset the store clears one cell a
// cycle, all LINES * 2**ceil(log2(COLUMNS)) cells (12800 by default), taking no input.
module key_driven_text_line_editor #(
  parameter int unsigned LINES   = kdtle_pkg::LinesDefault,
  parameter int unsigned COLUMNS = kdtle_pkg::ColumnsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // scan_code, key_char, read_row, read_col, zero fill
  input  logic [kdtle_pkg::InDataWidth-1:0]     s_axis_tdata,
  // op
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // cursor_col, cursor_row, line_count, modified, running, font_scale,
  // background_index, cursor_visible, second_font, read_char, zero fill
  output logic [kdtle_pkg::OutDataWidth-1:0]    m_axis_tdata
);

  localparam int unsigned RW = $clog2(LINES);
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned LW = $clog2(LINES + 1);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned ChW = kdtle_pkg::CharWidth;

  logic [15:0] scan_code;
  logic [15:0] key_char;
  logic [6:0]  read_row;
  logic [6:0]  read_col;
  logic        accept;
  logic        key_go;

  // Editor state.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [LW-1:0] lines_q, lines_d;
  logic          modified_q, modified_d;
  logic          running_q, running_d;
  logic [1:0]    scale_q, scale_d;
  logic [3:0]    colour_q, colour_d;
  logic          visible_q, visible_d;
  logic          font_q, font_d;

  // Write plan of the item in the sequencer.
  logic          ex_valid_q, ex_valid_d;
  logic [2:0]    fill_left_q, fill_left_d;
  logic          term_q, term_d;
  logic [RW-1:0] wr_row_q, wr_row_d;
  logic [CW-1:0] wr_col_q, wr_col_d;
  logic [ChW-1:0] fill_ch_q, fill_ch_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          rd_in_q, rd_in_d;
  logic          ex_wr;
  logic          ex_rd;

  logic [2:0]    plan_fill;
  logic          plan_term;
  logic [RW-1:0] plan_row;
  logic [CW-1:0] plan_col;
  logic [CW-1:0] room;
  logic [2:0]    tab_fill;

  // Result stage.
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] o_col_q;
  logic [RW-1:0] o_row_q;
  logic [LW-1:0] o_lines_q;
  logic          o_mod_q, o_run_q, o_vis_q, o_font_q, o_in_q;
  logic [1:0]    o_scale_q;
  logic [3:0]    o_colour_q;
  logic [ChW-1:0] rd_data;
  logic [ChW-1:0] read_char;
  logic          store_busy;

  assign scan_code = s_axis_tdata[15:0];
  assign key_char  = s_axis_tdata[31:16];
  assign read_row  = s_axis_tdata[38:32];
  assign read_col  = s_axis_tdata[45:39];

  assign ex_wr  = ex_valid_q && ((fill_left_q != 3'd0) || term_q);
  assign ex_rd  = ex_valid_q && !ex_wr && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !store_busy && (!ex_valid_q || ex_rd);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign key_go = accept && !s_axis_tuser && running_q;

  assign room     = CW'(COLUMNS - 1) - col_q;
  assign tab_fill = (room >= CW'(4)) ? kdtle_pkg::TabSpaces : room[2:0];

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    lines_d    = lines_q;
    modified_d = modified_q;
    running_d  = running_q;
    scale_d    = scale_q;
    colour_d   = colour_q;
    visible_d  = visible_q;
    font_d     = font_q;
    plan_fill  = 3'd0;
    plan_term  = 1'b0;
    plan_row   = row_q;
    plan_col   = col_q;
    if (key_go) begin
      priority if (scan_code == kdtle_pkg::ScanEscape) begin
        running_d = 1'b0;
      end else if (scan_code >= kdtle_pkg::ScanF1 && scan_code <= kdtle_pkg::ScanF8) begin
        unique case (scan_code)
          kdtle_pkg::ScanF2: begin
            if (scale_q > kdtle_pkg::ScaleMin) scale_d = scale_q - 2'd1;
          end
          kdtle_pkg::ScanF3: begin
            if (scale_q < kdtle_pkg::ScaleMax) scale_d = scale_q + 2'd1;
          end
          kdtle_pkg::ScanF4: begin
            colour_d = (colour_q == kdtle_pkg::ColourLast) ? 4'd0 : colour_q + 4'd1;
          end
          kdtle_pkg::ScanF5: visible_d = !visible_q;
          kdtle_pkg::ScanF6: font_d = !font_q;
          default: ;
        endcase
      end else if (key_char == kdtle_pkg::CharBackspace) begin
        if (col_q != '0) begin
          col_d      = col_q - CW'(1);
          plan_col   = col_q - CW'(1);
          plan_term  = 1'b1;
          modified_d = 1'b1;
        end
      end else if (key_char == kdtle_pkg::CharTab) begin
        plan_fill  = tab_fill;
        plan_term  = 1'b1;
        col_d      = col_q + CW'(tab_fill);
        modified_d = 1'b1;
      end else if (key_char == kdtle_pkg::CharReturn || key_char == kdtle_pkg::CharLineFeed) begin
        if (row_q < RW'(LINES - 1)) begin
          row_d      = row_q + RW'(1);
          col_d      = '0;
          lines_d    = LW'(row_q) + LW'(2);
          plan_row   = row_q + RW'(1);
          plan_col   = '0;
          plan_term  = 1'b1;
          modified_d = 1'b1;
        end
      end else if (key_char >= kdtle_pkg::CharSpace && key_char < kdtle_pkg::CharDelete) begin
        if (col_q < CW'(COLUMNS - 1)) begin
          col_d      = col_q + CW'(1);
          plan_fill  = 3'd1;
          plan_term  = 1'b1;
          modified_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ex_valid_d  = ex_valid_q;
    fill_left_d = fill_left_q;
    term_d      = term_q;
    wr_row_d    = wr_row_q;
    wr_col_d    = wr_col_q;
    fill_ch_d   = fill_ch_q;
    rd_addr_d   = rd_addr_q;
    rd_in_d     = rd_in_q;
    if (ex_wr) begin
      if (fill_left_q != 3'd0) begin
        fill_left_d = fill_left_q - 3'd1;
        wr_col_d    = wr_col_q + CW'(1);
      end else begin
        term_d = 1'b0;
      end
    end
    if (ex_rd) begin
      ex_valid_d = 1'b0;
    end
    if (accept) begin
      ex_valid_d  = 1'b1;
      fill_left_d = plan_fill;
      term_d      = plan_term;
      wr_row_d    = plan_row;
      wr_col_d    = plan_col;
      fill_ch_d   = (key_char == kdtle_pkg::CharTab) ? kdtle_pkg::CharSpace[ChW-1:0]
                                                     : key_char[ChW-1:0];
      rd_addr_d   = {read_row[RW-1:0], read_col[CW-1:0]};
      rd_in_d     = ({1'b0, read_row} < 8'(LINES)) && ({1'b0, read_col} < 8'(COLUMNS));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ex_rd) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      lines_q     <= LW'(1);
      modified_q  <= 1'b0;
      running_q   <= 1'b1;
      scale_q     <= kdtle_pkg::ScaleMin;
      colour_q    <= 4'd1;
      visible_q   <= 1'b1;
      font_q      <= 1'b0;
      ex_valid_q  <= 1'b0;
      fill_left_q <= 3'd0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      lines_q     <= lines_d;
      modified_q  <= modified_d;
      running_q   <= running_d;
      scale_q     <= scale_d;
      colour_q    <= colour_d;
      visible_q   <= visible_d;
      font_q      <= font_d;
      ex_valid_q  <= ex_valid_d;
      fill_left_q <= fill_left_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_row_q  <= wr_row_d;
    wr_col_q  <= wr_col_d;
    fill_ch_q <= fill_ch_d;
    rd_addr_q <= rd_addr_d;
    rd_in_q   <= rd_in_d;
    if (ex_rd) begin
      o_col_q    <= col_q;
      o_row_q    <= row_q;
      o_lines_q  <= lines_q;
      o_mod_q    <= modified_q;
      o_run_q    <= running_q;
      o_scale_q  <= scale_q;
      o_colour_q <= colour_q;
      o_vis_q    <= visible_q;
      o_font_q   <= font_q;
      o_in_q     <= rd_in_q;
    end
  end

  kdtle_store #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ex_wr),
    .wr_addr_i ({wr_row_q, wr_col_q}),
    .wr_data_i ((fill_left_q != 3'd0) ? fill_ch_q : '0),
    .rd_en_i   (ex_rd),
    .rd_addr_i (rd_addr_q),
    .rd_data_o (rd_data),
    .busy_o    (store_busy)
  );

  assign read_char     = o_in_q ? rd_data : '0;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, read_char, o_font_q, o_vis_q, o_colour_q, o_scale_q,
                          o_run_q, o_mod_q, 7'(o_lines_q), 7'(o_row_q), 7'(o_col_q)};

`ifndef SYNTHESIS
  a_no_input_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !s_axis_tready)
    else $error("Input taken while the store is being cleared.");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_rd |=> m_axis_tvalid)
    else $error("Store read issued without a result following.");

  a_stopped_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |=> (!running_q && $stable(col_q) && $stable(row_q) && $stable(scale_q)))
    else $error("Editor state changed after it was stopped.");

  a_settings_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scale_q != 2'd0) && (colour_q <= kdtle_pkg::ColourLast) && (col_q <= CW'(COLUMNS - 1)))
    else $error("Setting or cursor column out of range.");
`endif

endmodule
